// ===== rtl/spdt_pkg.sv =====
// Shared types, codes and defaults for the socket port demultiplexer.
`timescale 1ns / 1ps

package spdt_pkg;

    // default number of slots in each port table
    localparam int SPDT_SLOTS = 16;

    // request kinds
    localparam logic [1:0] REQ_CLASSIFY = 2'd0;
    localparam logic [1:0] REQ_ADD      = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;

    // table selectors for add
    localparam logic [1:0] SEL_UDP = 2'd0;
    localparam logic [1:0] SEL_LIS = 2'd1;
    localparam logic [1:0] SEL_CON = 2'd2;

    // IP protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // result status codes
    localparam logic [2:0] STAT_DELIVER = 3'd0;
    localparam logic [2:0] STAT_DEFAULT = 3'd1;
    localparam logic [2:0] STAT_DISCARD = 3'd2;
    localparam logic [2:0] STAT_OK      = 3'd3;
    localparam logic [2:0] STAT_FAIL    = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    // search token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic       valid;
        logic [1:0] req;
        logic [7:0] proto;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [1:0] sel;
        logic [7:0] id;
        // first port matches seen so far
        logic       udp_hit;
        logic [7:0] udp_id;
        logic       lis_hit;
        logic [7:0] lis_id;
        logic       con_hit;
        logic [7:0] con_id;
        // a free slot has been claimed upstream
        logic       udp_free;
        logic       lis_free;
        logic       con_free;
        // a handle match for remove has been claimed upstream
        logic       udp_rm;
        logic       lis_rm;
        logic       con_rm;
    } token_t;

    // table update broadcast to every cell at the end of a pass
    typedef struct packed {
        logic       add_udp;
        logic       add_lis;
        logic       add_con;
        logic       rm_udp;
        logic       rm_lis;
        logic       rm_con;
        logic [7:0] id;
        logic [15:0] local_port;
        logic [15:0] remote_port;
    } commit_t;

endpackage

// ===== rtl/spdt_cell.sv =====
// One slot of each port table plus one stage of the search token chain.
`timescale 1ns / 1ps

module spdt_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  spdt_pkg::token_t tok_in,
    output spdt_pkg::token_t tok_out,
    input  spdt_pkg::commit_t commit
);
    import spdt_pkg::*;

    // slot contents
    logic        uv_reg, lv_reg, cv_reg;
    logic [7:0]  uid_reg, lid_reg, cid_reg;
    logic [15:0] ul_reg, ll_reg, cl_reg, cr_reg;

    // marks left by the last pass: this cell is the chosen slot
    logic        mk_ufree_reg, mk_lfree_reg, mk_cfree_reg;
    logic        mk_urm_reg, mk_lrm_reg, mk_crm_reg;

    token_t tok_reg, tok_next;
    logic   u_match, l_match, c_match;
    logic   u_rm, l_rm, c_rm;
    logic   u_free, l_free, c_free;

    // compares against this slot
    always_comb begin
        u_match = uv_reg && (ul_reg == tok_in.dport) && !tok_in.udp_hit;
        l_match = lv_reg && (ll_reg == tok_in.dport) && !tok_in.lis_hit;
        c_match = cv_reg && (cl_reg == tok_in.dport) && (cr_reg == tok_in.sport)
                  && !tok_in.con_hit;
        u_rm    = uv_reg && (uid_reg == tok_in.id) && !tok_in.udp_rm;
        l_rm    = lv_reg && (lid_reg == tok_in.id) && !tok_in.lis_rm;
        c_rm    = cv_reg && (cid_reg == tok_in.id) && !tok_in.con_rm;
        u_free  = !uv_reg && !tok_in.udp_free;
        l_free  = !lv_reg && !tok_in.lis_free;
        c_free  = !cv_reg && !tok_in.con_free;
    end

    // token update
    always_comb begin
        tok_next = tok_in;
        if (u_match) begin
            tok_next.udp_hit = 1'b1;
            tok_next.udp_id  = uid_reg;
        end
        if (l_match) begin
            tok_next.lis_hit = 1'b1;
            tok_next.lis_id  = lid_reg;
        end
        if (c_match) begin
            tok_next.con_hit = 1'b1;
            tok_next.con_id  = cid_reg;
        end
        tok_next.udp_free = tok_in.udp_free | u_free;
        tok_next.lis_free = tok_in.lis_free | l_free;
        tok_next.con_free = tok_in.con_free | c_free;
        tok_next.udp_rm   = tok_in.udp_rm | u_rm;
        tok_next.lis_rm   = tok_in.lis_rm | l_rm;
        tok_next.con_rm   = tok_in.con_rm | c_rm;
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // marks follow the token as it passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mk_ufree_reg <= 1'b0;
            mk_lfree_reg <= 1'b0;
            mk_cfree_reg <= 1'b0;
            mk_urm_reg   <= 1'b0;
            mk_lrm_reg   <= 1'b0;
            mk_crm_reg   <= 1'b0;
        end else if (tok_in.valid) begin
            mk_ufree_reg <= u_free;
            mk_lfree_reg <= l_free;
            mk_cfree_reg <= c_free;
            mk_urm_reg   <= u_rm;
            mk_lrm_reg   <= l_rm;
            mk_crm_reg   <= c_rm;
        end
    end

    // valid bits: set on add, cleared on remove
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uv_reg <= 1'b0;
            lv_reg <= 1'b0;
            cv_reg <= 1'b0;
        end else begin
            if (commit.add_udp && mk_ufree_reg) begin
                uv_reg <= 1'b1;
            end else if (commit.rm_udp && mk_urm_reg) begin
                uv_reg <= 1'b0;
            end
            if (commit.add_lis && mk_lfree_reg) begin
                lv_reg <= 1'b1;
            end else if (commit.rm_lis && mk_lrm_reg) begin
                lv_reg <= 1'b0;
            end
            if (commit.add_con && mk_cfree_reg) begin
                cv_reg <= 1'b1;
            end else if (commit.rm_con && mk_crm_reg) begin
                cv_reg <= 1'b0;
            end
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        if (commit.add_udp && mk_ufree_reg) begin
            uid_reg <= commit.id;
            ul_reg  <= commit.local_port;
        end
        if (commit.add_lis && mk_lfree_reg) begin
            lid_reg <= commit.id;
            ll_reg  <= commit.local_port;
        end
        if (commit.add_con && mk_cfree_reg) begin
            cid_reg <= commit.id;
            cl_reg  <= commit.local_port;
            cr_reg  <= commit.remote_port;
        end
    end

endmodule

// ===== rtl/socket_port_demux_table.sv =====
// Top level of the socket port demultiplexer: controller and chain of slot cells.
`timescale 1ns / 1ps

//  channel   dir  handshake                fields
//  s_        in   s_tvalid / s_tready      tuser: req_type, list_sel
//                                          tdata: protocol, dport, sport, socket_id
//  m_        out  m_tvalid / m_tready      tuser: status   tdata: target_id
//  cfg_      in   cfg_valid / cfg_ready    cfg_data: drop_udp
//
//  A result follows the accepting cycle in steps: the search token meets the first cell
//  in the accepting cycle and one more cell per cycle, then the finished token is latched,
//  then the tables are updated and the output register loaded once that register is free.
//  One word is in work at a time: a new word is taken only once the last has left S_FIN.
//  Reset empties all tables at once (valid bits) and clears drop_udp.
//  A stalled result holds in the output register; the next word is accepted meanwhile.

module socket_port_demux_table #(
    parameter int SLOTS = spdt_pkg::SPDT_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // protocol[7:0], dport[23:8], sport[39:24],
                                   // socket_id[47:40]
    input  logic [3:0]  s_tuser,   // req_type[1:0], list_sel[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // target_id[7:0]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import spdt_pkg::*;

    state_t  state_reg, state_next;
    token_t  tok [SLOTS+1];
    token_t  fin_reg;
    commit_t commit;
    logic    drop_udp_reg;
    logic    m_valid_reg;
    logic [2:0] m_status_reg;
    logic [7:0] m_target_reg;
    logic    in_acc, chain_done, out_free, fin_load, out_load;
    logic [2:0] res_status;
    logic [7:0] res_target;

    // config register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_udp_reg <= 1'b0;
        end else if (cfg_valid) begin
            drop_udp_reg <= cfg_data;
        end
    end

    assign in_acc     = s_tvalid && s_tready;
    assign chain_done = tok[SLOTS].valid;
    assign out_free   = !m_valid_reg || m_tready;

    // token entering the first cell
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = in_acc;
        tok[0].req   = s_tuser[1:0];
        tok[0].sel   = s_tuser[3:2];
        tok[0].proto = s_tdata[7:0];
        tok[0].dport = s_tdata[23:8];
        tok[0].sport = s_tdata[39:24];
        tok[0].id    = s_tdata[47:40];
    end

    // cell chain
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        spdt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .commit  (commit)
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_SCAN;
            S_SCAN:  if (chain_done) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_tready = 1'b0;
        fin_load = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_SCAN:  fin_load = chain_done;
            S_FIN:   out_load = out_free;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // finished token
    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg <= tok[SLOTS];
        end
    end

    // result and table update from the finished token
    always_comb begin
        res_status = STAT_FAIL;
        res_target = 8'd0;
        commit             = '0;
        commit.id          = fin_reg.id;
        commit.local_port  = fin_reg.dport;
        commit.remote_port = fin_reg.sport;
        case (fin_reg.req)
            REQ_CLASSIFY: begin
                res_status = STAT_DEFAULT;
                if (fin_reg.proto == PROTO_UDP) begin
                    if (drop_udp_reg) begin
                        res_status = STAT_DISCARD;
                    end else if (fin_reg.udp_hit) begin
                        res_status = STAT_DELIVER;
                        res_target = fin_reg.udp_id;
                    end
                end else if (fin_reg.proto == PROTO_TCP) begin
                    if (fin_reg.con_hit) begin
                        res_status = STAT_DELIVER;
                        res_target = fin_reg.con_id;
                    end else if (fin_reg.lis_hit) begin
                        res_status = STAT_DELIVER;
                        res_target = fin_reg.lis_id;
                    end
                end
            end
            REQ_ADD: begin
                if (fin_reg.id != 8'd0) begin
                    case (fin_reg.sel)
                        SEL_UDP: commit.add_udp = fin_reg.udp_free && out_load;
                        SEL_LIS: commit.add_lis = fin_reg.lis_free && out_load;
                        SEL_CON: commit.add_con = fin_reg.con_free && out_load;
                        default: commit.add_udp = 1'b0;
                    endcase
                    if ((fin_reg.sel == SEL_UDP && fin_reg.udp_free) ||
                        (fin_reg.sel == SEL_LIS && fin_reg.lis_free) ||
                        (fin_reg.sel == SEL_CON && fin_reg.con_free)) begin
                        res_status = STAT_OK;
                    end
                end
            end
            REQ_REMOVE: begin
                if (fin_reg.id != 8'd0) begin
                    // listener first, then UDP, then connected
                    if (fin_reg.lis_rm) begin
                        commit.rm_lis = out_load;
                        res_status    = STAT_OK;
                    end else if (fin_reg.udp_rm) begin
                        commit.rm_udp = out_load;
                        res_status    = STAT_OK;
                    end else if (fin_reg.con_rm) begin
                        commit.rm_con = out_load;
                        res_status    = STAT_OK;
                    end
                end
            end
            default: res_status = STAT_FAIL;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status;
            m_target_reg <= res_target;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_target_reg;

`ifndef SYNTH
    // a token leaves the chain only while a scan is in progress
    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_done |-> state_reg == S_SCAN)
        else $error("token left the cell chain outside a scan");

    // an accepted word starts a scan
    a_acc_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> state_reg == S_SCAN)
        else $error("accepted word did not start a scan");

    // at most one table update per word
    a_commit_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({commit.add_udp, commit.add_lis, commit.add_con,
                  commit.rm_udp, commit.rm_lis, commit.rm_con}))
        else $error("more than one table update at once");

    // a delivered word names a socket, any other status names none
    a_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == STAT_DELIVER) == (m_tdata != 8'd0)))
        else $error("target handle disagrees with status");

    // table updates happen only when the result is loaded
    a_commit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit.add_udp || commit.add_lis || commit.add_con ||
         commit.rm_udp || commit.rm_lis || commit.rm_con) |=> m_tvalid)
        else $error("table update without a result");
`endif

endmodule
